@@ design/upr_pkg.sv @@
`default_nettype none
package upr_pkg;

   localparam int unsigned CsrIndexWidth = 3;

   // register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] CSR_STEP_TIME = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SPEED_MIN = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SPEED_MAX = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_MIN  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_TURN_MAX  = 3'd4;

   localparam logic [15:0] STEP_TIME_RESET = 16'd3277;
   localparam logic [15:0] SPEED_MIN_RESET = 16'hFF00;
   localparam logic [15:0] SPEED_MAX_RESET = 16'h0100;
   localparam logic [15:0] TURN_MIN_RESET  = 16'hE000;
   localparam logic [15:0] TURN_MAX_RESET  = 16'h2000;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // odd quintic sine in Q2.14
   localparam logic [14:0] SIN_A = 15'd25736;
   localparam logic [14:0] SIN_B = 15'd10512;
   localparam logic [16:0] SIN_C = 17'd1160;
   localparam logic [15:0] HDG_QUARTER = 16'd16384;

   localparam int unsigned MulAWidth = 32;
   localparam int unsigned MulBWidth = 17;
   localparam int unsigned MulPWidth = MulAWidth + MulBWidth;

   typedef struct packed {
      logic               op;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [15:0] start_heading;
      logic signed [15:0] speed;
      logic signed [15:0] turn_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] pose_heading;
   } rsp_type;

   typedef struct packed {
      logic        [15:0] step_time;
      logic signed [15:0] speed_min;
      logic signed [15:0] speed_max;
      logic signed [15:0] turn_min;
      logic signed [15:0] turn_max;
   } cfg_type;

   typedef struct packed {
      logic        neg;
      logic [14:0] mag;
   } fold_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_COEF,
      ST_P1,
      ST_P2,
      ST_TRIG,
      ST_SCALE,
      ST_ACC,
      ST_HDG,
      ST_DONE
   } upr_state_type;

endpackage
`default_nettype wire

@@ design/upr_mul.sv @@
`default_nettype none
module upr_mul
   import upr_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic signed [MulAWidth-1:0] mul_a,
   input  wire logic signed [MulBWidth-1:0] mul_b,
   output logic signed [MulPWidth-1:0]      mul_q
);

   logic signed [MulPWidth-1:0] prod_ff;
   logic signed [MulPWidth-1:0] prod_in;

   assign prod_in = MulPWidth'(mul_a) * MulPWidth'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_q = prod_ff;

endmodule
`default_nettype wire

@@ design/upr_csr.sv @@
`default_nettype none
module upr_csr
   import upr_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [15:0]              csr_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_TIME: cfg_in.step_time = csr_data;
            CSR_SPEED_MIN: cfg_in.speed_min = csr_data;
            CSR_SPEED_MAX: cfg_in.speed_max = csr_data;
            CSR_TURN_MIN:  cfg_in.turn_min  = csr_data;
            CSR_TURN_MAX:  cfg_in.turn_max  = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_time <= STEP_TIME_RESET;
         cfg_ff.speed_min <= SPEED_MIN_RESET;
         cfg_ff.speed_max <= SPEED_MAX_RESET;
         cfg_ff.turn_min  <= TURN_MIN_RESET;
         cfg_ff.turn_max  <= TURN_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ design/unicycle_pose_rollout.sv @@
// Unicycle pose rollout: a start beat (op 0) loads x, y and heading and returns them; a
// step beat (op 1) clamps speed and turn rate to the configured limits and advances the
// stored pose by one Euler step using the old heading. Every accepted beat gives exactly
// one result beat. All products go through one registered 32x17 signed multiplier under
// a small sequencer: cosine and sine each take four products of the quintic plus two for
// speed times step time, and one more forms the heading increment. The input stalls from
// acceptance until the result moves to the output register; the result sits in that
// output register, so the next beat is accepted while it waits.
// Configuration writes are taken every cycle and must happen only while the block is idle.
`default_nettype none
module unicycle_pose_rollout
   import upr_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [15:0]              csr_data
);

   localparam logic [MulPWidth-1:0] HALF_POS = MulPWidth'(1) << 21;
   localparam logic [MulPWidth-1:0] HALF_HDG = MulPWidth'(1) << 15;

   function automatic logic signed [15:0] clamp_lim(input logic signed [15:0] v,
                                                    input logic signed [15:0] lo,
                                                    input logic signed [15:0] hi);
      logic signed [15:0] r;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   // fold the angle to a quarter turn either side of zero
   function automatic fold_type fold_angle(input logic [15:0] ang);
      logic signed [17:0] t;
      fold_type r;
      t = {{2{ang[15]}}, ang};
      if (t > 18'sd16384) t = 18'sd32768 - t;
      else if (t < -18'sd16384) t = -18'sd32768 - t;
      r.neg = t[17];
      r.mag = t[17] ? 15'(-t) : 15'(t);
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] cur,
                                                  input logic [26:0] d);
      logic [32:0] s;
      logic signed [31:0] r;
      s = {cur[31], cur} + {{6{d[26]}}, d};
      if (s[32] != s[31]) r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else r = s[31:0];
      return r;
   endfunction

   cfg_type cfg;

   upr_state_type state_ff, state_in;
   logic          phase_sin_ff, phase_sin_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic [15:0]   h_ff, h_in;
   logic signed [15:0] v_ff, v_in, w_ff, w_in;
   logic [14:0]   m_ff, m_in, m2_ff, m2_in;
   logic          neg_ff, neg_in;

   logic signed [MulAWidth-1:0] mul_a;
   logic signed [MulBWidth-1:0] mul_b;
   logic signed [MulPWidth-1:0] mul_q;

   logic [15:0]          fold_ang;
   fold_type             fold_res;
   logic [MulPWidth-1:0] rnd_sum;
   logic [14:0]          p1, p2;
   logic [15:0]          trig_mag;
   logic [16:0]          trig;

   upr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   upr_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q)
   );

   // cosine is the sine a quarter turn ahead
   assign fold_ang = (state_ff == ST_IDLE) ? h_ff + HDG_QUARTER : h_ff;
   assign fold_res = fold_angle(fold_ang);

   // round half away from zero: negative products get one less before the shift
   assign rnd_sum = mul_q + ((state_ff == ST_HDG) ? HALF_HDG : HALF_POS)
                    - {{(MulPWidth-1){1'b0}}, mul_q[MulPWidth-1]};

   assign p1       = SIN_B - {4'd0, mul_q[24:14]};
   assign p2       = SIN_A - {1'b0, mul_q[27:14]};
   assign trig_mag = mul_q[29:14];
   assign trig     = neg_ff ? 17'(-{1'b0, trig_mag}) : {1'b0, trig_mag};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      phase_sin_in = phase_sin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      m_in         = m_ff;
      m2_in        = m2_ff;
      neg_in       = neg_ff;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.op == OP_START) begin
                  x_in     = req_data.start_x;
                  y_in     = req_data.start_y;
                  h_in     = req_data.start_heading;
                  state_in = ST_DONE;
               end else begin
                  v_in         = clamp_lim(req_data.speed, cfg.speed_min, cfg.speed_max);
                  w_in         = clamp_lim(req_data.turn_rate, cfg.turn_min, cfg.turn_max);
                  m_in         = fold_res.mag;
                  neg_in       = fold_res.neg;
                  phase_sin_in = 1'b0;
                  state_in     = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            mul_a    = {17'd0, m_ff};
            mul_b    = {2'd0, m_ff};
            state_in = ST_COEF;
         end
         ST_COEF: begin
            m2_in    = mul_q[28:14];
            mul_a    = {17'd0, mul_q[28:14]};
            mul_b    = SIN_C;
            state_in = ST_P1;
         end
         ST_P1: begin
            mul_a    = {17'd0, m2_ff};
            mul_b    = {2'd0, p1};
            state_in = ST_P2;
         end
         ST_P2: begin
            mul_a    = {17'd0, m_ff};
            mul_b    = {2'd0, p2};
            state_in = ST_TRIG;
         end
         ST_TRIG: begin
            mul_a    = {{16{v_ff[15]}}, v_ff};
            mul_b    = trig;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mul_a    = mul_q[31:0];
            mul_b    = {1'b0, cfg.step_time};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!phase_sin_ff) begin
               x_in         = add_sat(x_ff, rnd_sum[48:22]);
               m_in         = fold_res.mag;
               neg_in       = fold_res.neg;
               phase_sin_in = 1'b1;
               state_in     = ST_SQ;
            end else begin
               y_in     = add_sat(y_ff, rnd_sum[48:22]);
               mul_a    = {{16{w_ff[15]}}, w_ff};
               mul_b    = {1'b0, cfg.step_time};
               state_in = ST_HDG;
            end
         end
         ST_HDG: begin
            h_in     = h_ff + rnd_sum[31:16];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.pose_x       = x_ff;
               rsp_in.pose_y       = y_ff;
               rsp_in.pose_heading = h_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_sin_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         h_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         phase_sin_ff <= phase_sin_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         h_ff         <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      v_ff   <= v_in;
      w_ff   <= w_in;
      m_ff   <= m_in;
      m2_ff  <= m2_in;
      neg_ff <= neg_in;
   end

endmodule
`default_nettype wire

@@ design/upr_chk.sv @@
`default_nettype none
module upr_chk
   import upr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a result held back by the sink stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // the block is busy in the cycle after each accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after a beat");

   // a start beat with a free output echoes the pose through the done state and the output register
   a_start_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.op == OP_START && !rsp_valid
      |=> ##1 rsp_valid && rsp_data.pose_x == $past(req_data.start_x, 2)
              && rsp_data.pose_y == $past(req_data.start_y, 2)
              && rsp_data.pose_heading == $past(req_data.start_heading, 2))
      else $error("start pose not echoed");

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind unicycle_pose_rollout upr_chk u_upr_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
